@@ rtl/core/lurs_pkg.sv @@
// ----------------------------------------------------------------------------
// lurs_pkg
// Types and constants shared by the least-used route selector.
// ----------------------------------------------------------------------------
package lurs_pkg;

   localparam int NUM_ROUTES = 8;
   localparam int KEY_BITS   = 32;
   localparam int IDX_BITS   = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
   localparam int LIM_BITS   = $clog2(NUM_ROUTES + 1);
   localparam int COUNT_BITS = 32;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int RC_BITS       = 4;

   // configuration register indexes
   localparam logic [0:0] REG_ROUTE_COUNT = 1'b0;
   localparam logic [RC_BITS-1:0] ROUTE_COUNT_RESET = RC_BITS'(1);

   // operation codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SELECT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [2:0]  entry_index;
      logic        entry_balanced;
      logic [31:0] flow_key;
      logic        hold_route;
   } req_type;

   typedef struct packed {
      logic [2:0] chosen_index;
      logic       from_balance;
   } rsp_type;

   typedef struct packed {
      logic                  balanced;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   typedef struct packed {
      logic                  load_en;
      logic                  bump_en;
      logic [IDX_BITS-1:0]   idx;
      logic                  balanced;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
   } tbl_wr_type;

   typedef struct packed {
      logic                  hit;
      logic [COUNT_BITS-1:0] count_inc;
   } cmp_out_type;

endpackage

@@ rtl/core/lurs_table.sv @@
// ----------------------------------------------------------------------------
// lurs_table
// Route entry storage: one write port, one read port.
// ----------------------------------------------------------------------------
module lurs_table import lurs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  tbl_wr_type          wr,
   input  logic [IDX_BITS-1:0] rd_idx,
   output entry_type           rd_entry
);

   entry_type entry_ff [NUM_ROUTES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ROUTES; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (wr.load_en) begin
         entry_ff[wr.idx].balanced <= wr.balanced;
         entry_ff[wr.idx].key      <= wr.key;
         entry_ff[wr.idx].count    <= '0;
      end else if (wr.bump_en) begin
         entry_ff[wr.idx].count <= wr.count;
      end
   end

   assign rd_entry = entry_ff[rd_idx];

endmodule

@@ rtl/core/lurs_cmp.sv @@
// ----------------------------------------------------------------------------
// lurs_cmp
// Shared compare unit: key match, least-count compare, saturating increment.
// ----------------------------------------------------------------------------
module lurs_cmp import lurs_pkg::*; (
   input  entry_type             entry,
   input  logic [KEY_BITS-1:0]   key,
   input  logic                  found,
   input  logic [COUNT_BITS-1:0] best_count,
   output cmp_out_type           result
);

   logic match;

   always_comb begin
      match = entry.balanced && (entry.key == key);
      result.hit = match && (!found || (entry.count < best_count));
      result.count_inc = (&entry.count) ? entry.count : entry.count + 1'b1;
   end

endmodule

@@ rtl/core/lurs_csr.sv @@
// ----------------------------------------------------------------------------
// lurs_csr
// Configuration register port holding the route count.
// ----------------------------------------------------------------------------
module lurs_csr import lurs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [RC_BITS-1:0]       route_count
);

   logic [RC_BITS-1:0] route_count_ff;
   logic               sel_rc;

   assign sel_rc = (paddr[2] == REG_ROUTE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         route_count_ff <= ROUTE_COUNT_RESET;
      end else if (psel && penable && pwrite && sel_rc) begin
         route_count_ff <= pwdata[RC_BITS-1:0];
      end
   end

   assign prdata      = sel_rc ? CSR_DATA_BITS'(route_count_ff) : '0;
   assign pready      = 1'b1;
   assign route_count = route_count_ff;

endmodule

@@ rtl/core/least_used_route_selector.sv @@
// ----------------------------------------------------------------------------
// least_used_route_selector
// Route table with least-used selection, hold and remove of the last route.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_data (req_type)
//   rsp      out        rsp_valid/rsp_ready   rsp_data (rsp_type)
//   csr      in         psel/penable/pwrite   paddr, pwdata, prdata
//
// load, remove and unused codes finish in the transfer cycle itself.
// a select scans min(route_count, NUM_ROUTES) entries one per cycle through
// the shared compare unit, then a bump step writes the count and an output
// step loads the output register; a hold on a remembered route or an empty scan skips the scan.
// synchronous reset clears the table and the remembered route and sets
// route_count to 1.
// a result waiting on rsp_ready holds the sequencer in its output step.
// ----------------------------------------------------------------------------
module least_used_route_selector import lurs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_BUMP = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [IDX_BITS-1:0]   scan_ff, scan_in;
   logic [IDX_BITS-1:0]   scan_last_ff, scan_last_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   chosen_ff, chosen_in;
   logic [COUNT_BITS-1:0] best_count_ff, best_count_in;
   logic [IDX_BITS-1:0]   last_index_ff, last_index_in;
   logic                  last_valid_ff, last_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [RC_BITS-1:0]    route_count;
   logic [LIM_BITS-1:0]   limit;
   logic                  req_xfer;
   tbl_wr_type            tbl_wr;
   logic [IDX_BITS-1:0]   rd_idx;
   entry_type             rd_entry;
   cmp_out_type           cmp;

   lurs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .route_count (route_count)
   );

   lurs_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry)
   );

   lurs_cmp u_cmp (
      .entry      (rd_entry),
      .key        (key_ff),
      .found      (found_ff),
      .best_count (best_count_ff),
      .result     (cmp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rd_idx    = (state_ff == ST_BUMP) ? chosen_ff : scan_ff;
   assign limit     = (32'(route_count) > NUM_ROUTES) ? LIM_BITS'(NUM_ROUTES)
                                                      : LIM_BITS'(route_count);

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      scan_last_in  = scan_last_ff;
      key_in        = key_ff;
      found_in      = found_ff;
      chosen_in     = chosen_ff;
      best_count_in = best_count_ff;
      last_index_in = last_index_ff;
      last_valid_in = last_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      tbl_wr          = '0;
      tbl_wr.idx      = IDX_BITS'(req_data.entry_index);
      tbl_wr.balanced = req_data.entry_balanced;
      tbl_wr.key      = KEY_BITS'(req_data.flow_key);
      tbl_wr.count    = cmp.count_inc;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_data.operation)
                  OP_LOAD: begin
                     tbl_wr.load_en = (32'(req_data.entry_index) < NUM_ROUTES);
                  end
                  OP_REMOVE: begin
                     if (last_valid_ff &&
                         (32'(last_index_ff) == 32'(req_data.entry_index))) begin
                        last_valid_in = 1'b0;
                     end
                  end
                  OP_SELECT: begin
                     key_in    = KEY_BITS'(req_data.flow_key);
                     scan_in   = '0;
                     found_in  = 1'b0;
                     chosen_in = '0;
                     if (req_data.hold_route && last_valid_ff) begin
                        chosen_in = last_index_ff;
                        found_in  = 1'b1;
                        state_in  = ST_BUMP;
                     end else if (limit == '0) begin
                        state_in = ST_BUMP;
                     end else begin
                        scan_last_in = IDX_BITS'(limit - 1'b1);
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cmp.hit) begin
               found_in      = 1'b1;
               chosen_in     = scan_ff;
               best_count_in = rd_entry.count;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == scan_last_ff) begin
               state_in = ST_BUMP;
            end
         end
         ST_BUMP: begin
            // read-modify-write of the chosen entry's count
            tbl_wr.bump_en = 1'b1;
            tbl_wr.idx     = chosen_ff;
            last_index_in  = chosen_ff;
            last_valid_in  = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.chosen_index = 3'(chosen_ff);
               rsp_data_in.from_balance = found_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_index_ff <= '0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_index_ff <= last_index_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      scan_last_ff  <= scan_last_in;
      key_ff        <= key_in;
      found_ff      <= found_in;
      chosen_ff     <= chosen_in;
      best_count_ff <= best_count_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for least_used_route_selector. Loads route entries, requests
// selections with and without hold and removes remembered routes, over several
// route_count settings. A scoreboard tracks the route table, predicts each
// selection and checks every response in order. Both channels see random
// gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import lurs_pkg::*;

   localparam int CLK_HALF      = 4;
   localparam int SETTLE_CYCLES = NUM_ROUTES + 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 122;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] ROUTE_COUNT_ADDR =
      CSR_ADDR_BITS'({REG_ROUTE_COUNT, 2'b00});

   // route table mirror and queue of pending selections
   class route_scoreboard;
      logic [COUNT_BITS-1:0] use_cnt[NUM_ROUTES];
      logic                  bal_flag[NUM_ROUTES];
      logic [KEY_BITS-1:0]   key_tbl[NUM_ROUTES];
      logic [2:0]            last_idx;
      logic                  last_vld;
      logic [RC_BITS-1:0]    route_count;
      rsp_type               expected_routes[$];
      int                    mismatch_count;

      function new();
         for (int i = 0; i < NUM_ROUTES; i++) begin
            use_cnt[i]  = '0;
            bal_flag[i] = 1'b0;
            key_tbl[i]  = '0;
         end
         last_idx       = '0;
         last_vld       = 1'b0;
         route_count    = ROUTE_COUNT_RESET;
         mismatch_count = 0;
      endfunction

      function void set_route_count(logic [RC_BITS-1:0] v);
         route_count = v;
      endfunction

      function int pending();
         return expected_routes.size();
      endfunction

      function void note_request(req_type r);
         int                    lim;
         logic                  found;
         logic [2:0]            best;
         logic [COUNT_BITS-1:0] best_cnt;
         rsp_type               e;
         case (r.operation)
            OP_LOAD: begin
               if (int'(r.entry_index) < NUM_ROUTES) begin
                  bal_flag[r.entry_index] = r.entry_balanced;
                  key_tbl[r.entry_index]  = r.flow_key[KEY_BITS-1:0];
                  use_cnt[r.entry_index]  = '0;
               end
            end
            OP_REMOVE: begin
               if (last_vld && last_idx == r.entry_index) last_vld = 1'b0;
            end
            OP_SELECT: begin
               if (r.hold_route && last_vld) begin
                  e.chosen_index = last_idx;
                  e.from_balance = 1'b1;
               end else begin
                  lim      = (int'(route_count) > NUM_ROUTES) ? NUM_ROUTES : int'(route_count);
                  found    = 1'b0;
                  best     = '0;
                  best_cnt = '0;
                  for (int i = 0; i < lim; i++) begin
                     if (bal_flag[i] && key_tbl[i] == r.flow_key[KEY_BITS-1:0] &&
                         (!found || use_cnt[i] < best_cnt)) begin
                        found    = 1'b1;
                        best     = 3'(i);
                        best_cnt = use_cnt[i];
                     end
                  end
                  e.chosen_index = best;
                  e.from_balance = found;
               end
               // count saturates at all ones
               if (use_cnt[e.chosen_index] != '1)
                  use_cnt[e.chosen_index] = use_cnt[e.chosen_index] + 1'b1;
               last_idx = e.chosen_index;
               last_vld = 1'b1;
               expected_routes.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_response(rsp_type r);
         rsp_type e;
         if (expected_routes.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual index %0d balance %0b",
                     $time, r.chosen_index, r.from_balance);
            mismatch_count++;
         end else begin
            e = expected_routes.pop_front();
            if (r.chosen_index !== e.chosen_index) begin
               $display("%0t: chosen_index mismatch, expected %0d, actual %0d",
                        $time, e.chosen_index, r.chosen_index);
               mismatch_count++;
            end
            if (r.from_balance !== e.from_balance) begin
               $display("%0t: from_balance mismatch, expected %0b, actual %0b",
                        $time, e.from_balance, r.from_balance);
               mismatch_count++;
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   route_scoreboard sb = new();
   logic [31:0]     key_pool[3];
   logic            no_idle = 1'b0;

   least_used_route_selector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic req_type mk_req(logic [1:0] op, logic [2:0] idx, logic bal,
                                      logic [31:0] key, logic hold);
      req_type r;
      r.operation      = op;
      r.entry_index    = idx;
      r.entry_balanced = bal;
      r.flow_key       = key;
      r.hold_route     = hold;
      return r;
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int      p;
      p                = $urandom_range(0, 99);
      r.entry_index    = 3'($urandom_range(0, NUM_ROUTES - 1));
      r.entry_balanced = ($urandom_range(0, 9) < 8);
      r.flow_key       = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 2)]
                                                    : $urandom;
      r.hold_route     = ($urandom_range(0, 9) < 3);
      if (p < 35)      r.operation = OP_LOAD;
      else if (p < 80) r.operation = OP_SELECT;
      else if (p < 95) r.operation = OP_REMOVE;
      else             r.operation = OP_UNUSED;
      return r;
   endfunction

   // responses are checked at the transfer edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // receiver with random stalls
   initial begin
      int stall;
      stall     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            rsp_ready <= 1'b1;
            stall = 0;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) stall = pick_gap();
         end
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL least_used_route_selector");
      $finish;
   end

   task automatic send_req(req_type r);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_route_count(logic [RC_BITS-1:0] v);
      wait_idle();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ROUTE_COUNT_ADDR;
      pwdata  <= CSR_DATA_BITS'(v);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_route_count(v);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic run_directed();
      // nothing remembered yet, nothing balanced: falls back to entry zero
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'h0, 1'b1));
      send_req(mk_req(OP_UNUSED, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1));
      send_req(mk_req(OP_REMOVE, 3'd0, 1'b0, 32'h0, 1'b0));
      write_route_count(RC_BITS'(NUM_ROUTES));
      for (int i = 0; i < NUM_ROUTES; i++)
         send_req(mk_req(OP_LOAD, 3'(i), (i != 2), (i < 4) ? 32'hFFFF_FFFF : 32'h0, 1'b0));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'hFFFF_FFFF, 1'b0));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'hFFFF_FFFF, 1'b0));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'h0, 1'b1));
      // remove of another entry leaves the remembered route
      send_req(mk_req(OP_REMOVE, 3'd5, 1'b0, 32'h0, 1'b0));
      send_req(mk_req(OP_REMOVE, 3'd1, 1'b0, 32'h0, 1'b0));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'hFFFF_FFFF, 1'b1));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'h1234_5678, 1'b0));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'h0, 1'b0));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'h0, 1'b0));
      // stale hold beyond a shorter scan
      write_route_count(RC_BITS'(2));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'h0, 1'b1));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'h0, 1'b0));
      write_route_count('0);
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'hFFFF_FFFF, 1'b0));
      write_route_count('1);
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'hFFFF_FFFF, 1'b0));
      send_req(mk_req(OP_SELECT, 3'd0, 1'b0, 32'hFFFF_FFFF, 1'b0));
   endtask

   initial begin
      logic [RC_BITS-1:0] rc;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       rc = RC_BITS'(NUM_ROUTES);
            1:       rc = RC_BITS'(1);
            2:       rc = '1;
            3:       rc = '0;
            default: rc = RC_BITS'($urandom_range(0, 15));
         endcase
         write_route_count(rc);
         no_idle = (p == 4 || p == 7);
         for (int k = 0; k < 3; k++) key_pool[k] = $urandom;
         // fill the table so selections find matching entries
         for (int i = 0; i < NUM_ROUTES; i++)
            send_req(mk_req(OP_LOAD, 3'(i), ($urandom_range(0, 99) < 85),
                            key_pool[$urandom_range(0, 2)], 1'b0));
         for (int n = 0; n < PHASE_ITEMS; n++) send_req(rand_req());
      end

      wait_idle();
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("PASS least_used_route_selector");
      end else begin
         $display("FAIL least_used_route_selector");
      end
      $finish;
   end

endmodule

@@ least_used_route_selector.f @@
rtl/core/lurs_pkg.sv
rtl/core/lurs_table.sv
rtl/core/lurs_cmp.sv
rtl/core/lurs_csr.sv
rtl/core/least_used_route_selector.sv
verif/tb.sv
